>>> rtl/eptm_pkg.sv
package eptm_pkg;

  // Fixed field widths of the request and result items
  localparam int DATA_W  = 8;
  localparam int TAP_W   = 7;
  localparam int IDX_W   = 7;
  localparam int WORD_W  = 32;
  localparam int ROT_W   = 5;
  localparam int REG_W   = 3;
  localparam int NUM_TAP = 5;
  localparam int NUM_RD  = NUM_TAP + 1;

  // Configuration register indexes
  localparam logic [REG_W-1:0] CFG_TAP_FIRST  = 3'd0;
  localparam logic [REG_W-1:0] CFG_TAP_SECOND = 3'd1;
  localparam logic [REG_W-1:0] CFG_TAP_THIRD  = 3'd2;
  localparam logic [REG_W-1:0] CFG_TAP_FOURTH = 3'd3;
  localparam logic [REG_W-1:0] CFG_TAP_FIFTH  = 3'd4;

  // Tap offsets after reset, in register order
  localparam logic [TAP_W-1:0] TAP_RESET [NUM_TAP] = '{7'd104, 7'd76, 7'd51, 7'd25, 7'd1};

  // Rotate advance: normal step and step taken when the pointer lands on zero
  localparam logic [ROT_W-1:0] ROT_STEP      = 5'd7;
  localparam logic [ROT_W-1:0] ROT_STEP_WRAP = 5'd14;

  // Twist table folded in by the low three bits of the mixed word
  localparam logic [WORD_W-1:0] TWIST [8] = '{
    32'h00000000, 32'h3b6e20c8, 32'h76dc4190, 32'h4db26158,
    32'hedb88320, 32'hd6d6a3e8, 32'h9b64c2b0, 32'ha00ae278
  };

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic [ROT_W-1:0]  rotate_next;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] index;
    logic [TAP_W-1:0] data;
  } cfg_req_t;

endpackage

>>> rtl/eptm_stream_if.sv
interface eptm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/entropy_pool_twist_mixer.sv
// Entropy pool twist mixer: folds a byte stream into a pool of POOL_WORDS
// 32-bit words with a twisted GFSR.
// Channels: in_ch takes one byte per request (data_byte, buffer_end);
// out_ch returns one result per request (word_index, word_value,
// rotate_next, last) in request order; cfg_ch writes the five tap offsets
// (index 0..4, other indexes are dropped) and is always ready. Write taps
// only while no request is in flight.
// Each result is registered in the output buffer, which drives out_ch.
// Throughput: one byte per cycle while in_ch.ready is high, set by six
// pool copies, each with one write and one registered read port, whose
// next addresses are prefetched from the pointer and taps for the following byte.
// Reset: pointer, rotate amount and taps return to their defaults, then a
// clearing pass zeroes the pool one word per cycle, words 0 to POOL_WORDS-1,
// with in_ch.ready low throughout.
// Stall: a two-entry output buffer keeps taking requests while one result
// waits; in_ch.ready drops once both entries are full.
module entropy_pool_twist_mixer #(
  parameter int POOL_WORDS = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  eptm_stream_if.sink   in_ch,
  eptm_stream_if.source out_ch,
  eptm_stream_if.sink   cfg_ch
);
  import eptm_pkg::*;

  localparam int AW = $clog2(POOL_WORDS);
  localparam int SW = ((AW > TAP_W) ? AW : TAP_W) + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_WORDS - 1);

  // Reduce a tap offset modulo the pool size (at most three subtractions)
  function automatic logic [TAP_W-1:0] tap_mod(input logic [TAP_W-1:0] t);
    int v;
    v = int'(t);
    for (int k = 0; k < 3; k++) begin
      if (v >= POOL_WORDS) begin
        v = v - POOL_WORDS;
      end
    end
    return TAP_W'(v);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                            input logic [TAP_W-1:0] t);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(t);
    if (s >= SW'(POOL_WORDS)) begin
      s = s - SW'(POOL_WORDS);
    end
    return AW'(s);
  endfunction

  logic [TAP_W-1:0] tap_r   [NUM_TAP];
  logic [TAP_W-1:0] tap_nxt [NUM_TAP];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [ROT_W-1:0] rot_r;
  logic             clr_r;
  logic [AW-1:0]    clr_cnt_r;

  logic             push;
  logic             has_room;
  logic [AW-1:0]    cur_ptr;
  logic [AW-1:0]    pre_ptr;
  logic [AW-1:0]    rd_addr [NUM_RD];
  logic [NUM_RD-1:0][WORD_W-1:0] rd_word;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WORD_W-1:0] wr_data;
  out_item_t        result;
  out_item_t        out_item;

  assign in_ch.ready  = !clr_r && has_room;
  assign cfg_ch.ready = 1'b1;
  assign push         = in_ch.valid && in_ch.ready;

  // Tap registers take the reduced offset on a write
  always_comb begin
    tap_nxt = tap_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        CFG_TAP_FIRST:  tap_nxt[0] = tap_mod(cfg_ch.payload.data);
        CFG_TAP_SECOND: tap_nxt[1] = tap_mod(cfg_ch.payload.data);
        CFG_TAP_THIRD:  tap_nxt[2] = tap_mod(cfg_ch.payload.data);
        CFG_TAP_FOURTH: tap_nxt[3] = tap_mod(cfg_ch.payload.data);
        CFG_TAP_FIFTH:  tap_nxt[4] = tap_mod(cfg_ch.payload.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TAP; k++) begin
        tap_r[k] <= tap_mod(TAP_RESET[k]);
      end
    end else begin
      tap_r <= tap_nxt;
    end
  end

  // Pointer and rotate advance on each request
  assign cur_ptr = ptr_dec(wp_r);
  assign wp_nxt  = push ? cur_ptr : wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rot_r <= '0;
    end else if (push) begin
      wp_r  <= wp_nxt;
      rot_r <= result.rotate_next;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST_IDX) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Prefetch addresses for the byte that follows
  always_comb begin
    pre_ptr    = ptr_dec(wp_nxt);
    rd_addr[0] = pre_ptr;
    for (int k = 0; k < NUM_TAP; k++) begin
      rd_addr[k+1] = ptr_add(pre_ptr, tap_nxt[k]);
    end
  end

  assign wr_en   = clr_r || push;
  assign wr_addr = clr_r ? clr_cnt_r : cur_ptr;
  assign wr_data = clr_r ? '0 : result.word_value;

  // One pool copy per read port
  for (genvar g = 0; g < NUM_RD; g++) begin : g_pool
    eptm_ram #(
      .DEPTH (POOL_WORDS),
      .WIDTH (WORD_W)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr[g]),
      .rd_data (rd_word[g])
    );
  end

  eptm_mix #(
    .AW (AW)
  ) u_mix (
    .item   (in_ch.payload),
    .rot    (rot_r),
    .ptr    (cur_ptr),
    .words  (rd_word),
    .result (result)
  );

  eptm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (result),
    .has_room  (has_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.payload = out_item;

  // Rotate amount moves by one of its two steps after each request
  a_rot_step: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (rot_r == 5'($past(rot_r) + ROT_STEP)) ||
             (rot_r == 5'($past(rot_r) + ROT_STEP_WRAP)))
    else $error("rotate amount did not advance by a legal step");

  // Pointer holds between requests
  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !push |=> $stable(wp_r))
    else $error("write pointer moved without a request");

  // out_ch holds a valid result in the cycle after every accepted request
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_ch.valid)
    else $error("accepted request produced no result");

  // No request is taken during the clearing pass
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !push && $stable(rot_r))
    else $error("request accepted while clearing the pool");
endmodule

>>> rtl/eptm_ram.sv
module eptm_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port, registered read with write-through on an address match
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

>>> rtl/eptm_mix.sv
module eptm_mix #(
  parameter int AW = 7
) (
  input  eptm_pkg::in_item_t                                    item,
  input  logic [eptm_pkg::ROT_W-1:0]                            rot,
  input  logic [AW-1:0]                                         ptr,
  input  logic [eptm_pkg::NUM_RD-1:0][eptm_pkg::WORD_W-1:0]     words,
  output eptm_pkg::out_item_t                                   result
);
  import eptm_pkg::*;

  logic [2*WORD_W-1:0] dbl;
  logic [WORD_W-1:0]   rotated;
  logic [WORD_W-1:0]   mixed;
  logic [WORD_W-1:0]   folded;
  logic [ROT_W-1:0]    step;

  // Rotate the byte, XOR in the pool word and the taps, fold with the twist
  always_comb begin
    dbl     = {WORD_W'(item.data_byte), WORD_W'(item.data_byte)} << rot;
    rotated = dbl[2*WORD_W-1:WORD_W];
    mixed   = rotated;
    for (int k = 0; k < NUM_RD; k++) begin
      mixed = mixed ^ words[k];
    end
    folded = (mixed >> 3) ^ TWIST[mixed[2:0]];
    step   = (ptr == '0) ? ROT_STEP_WRAP : ROT_STEP;

    result.word_index  = IDX_W'(ptr);
    result.word_value  = folded;
    result.rotate_next = rot + step;
    result.last        = item.buffer_end;
  end
endmodule

>>> rtl/eptm_outbuf.sv
module eptm_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  eptm_pkg::out_item_t push_item,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output eptm_pkg::out_item_t out_item
);
  import eptm_pkg::*;

  logic      head_valid_r;
  logic      skid_valid_r;
  out_item_t head_r;
  out_item_t skid_r;
  logic      pop;

  assign pop = head_valid_r && out_ready;

  // Control: head feeds the port, skid catches a request during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!head_valid_r || pop) begin
      head_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: advance skid into head, or take the new result
  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
      end else if (push) begin
        head_r <= push_item;
      end
    end else if (push) begin
      skid_r <= push_item;
    end
  end

  assign has_room  = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_item  = head_r;
endmodule
